// ===== rtl/dpi_pkg.sv =====
package dpi_pkg;

    // field and state widths
    localparam int MAG_W       = 15;
    localparam int LEN_W       = 8;
    localparam int RES_W       = 32;
    localparam int CONTRIB_W   = RES_W + 1;
    localparam int FLAGS_W     = 6;
    localparam int MASK_W      = 3;
    localparam int FLAG_LANES  = 3;
    localparam int DECAY_SHIFT = 7;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // reset values of the configuration registers
    localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(20000);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(20);

    // decay rounding term: 2^DECAY_SHIFT - 1
    localparam logic [RES_W:0] DECAY_ROUND = (CONTRIB_W)'((1 << DECAY_SHIFT) - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_MAG  = 2'd0,
        REG_SECOND_MAG = 2'd1,
        REG_THIRD_MAG  = 2'd2,
        REG_PULSE_LEN  = 2'd3
    } t_cfg_reg;

    // per-tick command to one lane
    typedef struct packed {
        logic step;
        logic ex;
        logic ih;
        logic decay;
    } t_lane_cmd;

    // lane state seen by the merge stage
    typedef struct packed {
        logic                        armed;
        logic signed [CONTRIB_W-1:0] contrib;
    } t_lane_out;

endpackage

// ===== rtl/dpi_lane.sv =====
module dpi_lane
    import dpi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lane_cmd        i_cmd,
    input  logic [MAG_W-1:0] i_magnitude,
    input  logic [LEN_W-1:0] i_pulse_length,
    output t_lane_out        o_status
);

    logic                    r_armed, n_armed;
    logic                    r_inh, n_inh;
    logic [LEN_W-1:0]        r_cnt, n_cnt;
    logic signed [RES_W-1:0] r_res, n_res;

    logic                    arm;
    logic                    inh1;
    logic                    armed1;
    logic [LEN_W-1:0]        cnt1;
    logic [LEN_W-1:0]        cnt2;
    logic signed [MAG_W:0]   smag_new;
    logic signed [RES_W:0]   res_sum;
    logic signed [RES_W-1:0] res2;
    logic [RES_W-1:0]        res_abs;
    logic [RES_W:0]          dec_wide;
    logic [RES_W-1:0]        dec_q;
    logic signed [RES_W-1:0] res_dec;
    logic signed [MAG_W:0]   smag_cur;

    // arm, count, fold into residual, decay
    always_comb begin
        arm    = i_cmd.ex | i_cmd.ih;
        armed1 = arm ? 1'b1 : r_armed;
        inh1   = arm ? i_cmd.ih : r_inh;
        cnt1   = arm ? '0 : r_cnt;
        cnt2   = cnt1 + LEN_W'(1);

        smag_new = inh1 ? -$signed({1'b0, i_magnitude}) : $signed({1'b0, i_magnitude});
        res_sum  = {r_res[RES_W-1], r_res} + CONTRIB_W'(smag_new);

        n_armed = armed1;
        n_inh   = inh1;
        n_cnt   = cnt1;
        res2    = r_res;
        if (armed1) begin
            if (cnt2 >= i_pulse_length) begin
                n_armed = 1'b0;
                n_cnt   = '0;
                if (res_sum[RES_W] != res_sum[RES_W-1]) begin
                    res2 = res_sum[RES_W] ? {1'b1, {(RES_W-1){1'b0}}}
                                          : {1'b0, {(RES_W-1){1'b1}}};
                end else begin
                    res2 = res_sum[RES_W-1:0];
                end
            end else begin
                n_cnt = cnt2;
            end
        end

        // times 127/128 toward zero: r -/+ ceil(|r| / 128)
        res_abs  = res2[RES_W-1] ? RES_W'(-res2) : RES_W'(res2);
        dec_wide = ({1'b0, res_abs} + DECAY_ROUND) >> DECAY_SHIFT;
        dec_q    = dec_wide[RES_W-1:0];
        res_dec  = res2[RES_W-1] ? res2 + $signed(dec_q) : res2 - $signed(dec_q);
        n_res    = i_cmd.decay ? res_dec : res2;
    end

    // lane state, advances once per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_inh   <= 1'b0;
            r_cnt   <= '0;
            r_res   <= '0;
        end else if (i_cmd.step) begin
            r_armed <= n_armed;
            r_inh   <= n_inh;
            r_cnt   <= n_cnt;
            r_res   <= n_res;
        end
    end

    // contribution of this lane to the potential
    always_comb begin
        smag_cur         = r_inh ? -$signed({1'b0, i_magnitude}) : $signed({1'b0, i_magnitude});
        o_status.armed   = r_armed;
        o_status.contrib = CONTRIB_W'(r_res)
                         + (r_armed ? CONTRIB_W'(smag_cur) : CONTRIB_W'(0));
    end

endmodule

// ===== rtl/dpi_merge.sv =====
module dpi_merge
    import dpi_pkg::*;
#(
    parameter int DENDRITES = 3
) (
    input  t_lane_out               i_lanes [DENDRITES],
    output logic signed [RES_W-1:0] o_potential,
    output logic [MASK_W-1:0]       o_armed_mask
);

    localparam int SUM_W = CONTRIB_W + $clog2(DENDRITES + 1);

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] max_pos;
    logic signed [SUM_W-1:0] min_neg;

    // sum the lanes and saturate
    always_comb begin
        sum = '0;
        for (int k = 0; k < DENDRITES; k++) begin
            sum = sum + SUM_W'(i_lanes[k].contrib);
        end
        max_pos = SUM_W'({1'b0, {(RES_W-1){1'b1}}});
        min_neg = -max_pos - SUM_W'(1);
        if (sum > max_pos) begin
            o_potential = {1'b0, {(RES_W-1){1'b1}}};
        end else if (sum < min_neg) begin
            o_potential = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            o_potential = sum[RES_W-1:0];
        end
    end

    // only the flagged dendrites show in the mask
    always_comb begin
        o_armed_mask = '0;
        for (int k = 0; k < MASK_W && k < DENDRITES; k++) begin
            o_armed_mask[k] = i_lanes[k].armed;
        end
    end

endmodule

// ===== rtl/dendrite_pulse_integrator.sv =====
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+------------------------------
// tick in   | input     | i_valid / o_ready  | i_pulse_flags, i_apply_decay
// result    | output    | o_valid / i_ready  | o_potential, o_armed_mask
// config    | input     | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One word per cycle sustained while i_ready stays high.
// The lane state registers take the word, then the lane sum is registered.
// Reset is synchronous on i_rst_n and needs no clearing pass.
// With the result held, one more word is taken into the lane state; then
// o_ready drops until the held result leaves.
module dendrite_pulse_integrator
    import dpi_pkg::*;
#(
    parameter int DENDRITES = 3
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [FLAGS_W-1:0]      i_pulse_flags,
    input  logic                    i_apply_decay,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [RES_W-1:0] o_potential,
    output logic [MASK_W-1:0]       o_armed_mask,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    logic [MAG_W-1:0] r_mag [DENDRITES];
    logic [LEN_W-1:0] r_len;

    logic                    r_s1_valid;
    logic                    r_out_valid;
    logic signed [RES_W-1:0] r_potential;
    logic [MASK_W-1:0]       r_mask;

    logic                    accept;
    logic                    s1_move;
    t_lane_cmd               cmd [DENDRITES];
    t_lane_out               lanes [DENDRITES];
    logic signed [RES_W-1:0] sum_potential;
    logic [MASK_W-1:0]       sum_mask;
    t_cfg_reg                cfg_reg;

    assign cfg_reg = t_cfg_reg'(i_cfg_index);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DENDRITES; k++) begin
                r_mag[k] <= MAG_RESET;
            end
            r_len <= LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (cfg_reg)
                REG_FIRST_MAG, REG_SECOND_MAG, REG_THIRD_MAG: begin
                    for (int k = 0; k < DENDRITES; k++) begin
                        if (k < FLAG_LANES && i_cfg_index == CFG_IDX_W'(k)) begin
                            r_mag[k] <= i_cfg_data[MAG_W-1:0];
                        end
                    end
                end
                REG_PULSE_LEN: r_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control: lane state holds one pending word, then the output register
    assign s1_move = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_move;
    assign accept  = i_valid && o_ready;

    // lanes
    for (genvar k = 0; k < DENDRITES; k++) begin : g_lane
        if (k < FLAG_LANES) begin : g_flagged
            always_comb begin
                cmd[k].step  = accept;
                cmd[k].decay = i_apply_decay;
                cmd[k].ex    = accept & i_pulse_flags[2*k];
                cmd[k].ih    = accept & i_pulse_flags[2*k+1];
            end
        end else begin : g_extra
            always_comb begin
                cmd[k].step  = accept;
                cmd[k].decay = i_apply_decay;
                cmd[k].ex    = 1'b0;
                cmd[k].ih    = 1'b0;
            end
        end

        dpi_lane u_lane (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_cmd          (cmd[k]),
            .i_magnitude    (r_mag[k]),
            .i_pulse_length (r_len),
            .o_status       (lanes[k])
        );
    end

    // merge
    dpi_merge #(
        .DENDRITES (DENDRITES)
    ) u_merge (
        .i_lanes      (lanes),
        .o_potential  (sum_potential),
        .o_armed_mask (sum_mask)
    );

    // pipeline valids and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_potential <= sum_potential;
            r_mask      <= sum_mask;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_potential  = r_potential;
    assign o_armed_mask = r_mask;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dpi_pkg::*;

    localparam longint RAIL_HI = 64'sd2147483647;
    localparam longint RAIL_LO = -64'sd2147483648;
    localparam longint DECAY_DEN = longint'(1) << DECAY_SHIFT;
    localparam longint DECAY_NUM = DECAY_DEN - 1;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [FLAGS_W-1:0] EX_ALL = 6'b010101;
    localparam logic [FLAGS_W-1:0] IH_ALL = 6'b101010;

    typedef struct {
        logic signed [RES_W-1:0] potential;
        logic [MASK_W-1:0]       mask;
    } t_tick_result;

    // tracks dendrite state and the potential words still owed by the block
    class potential_tracker;
        logic [MAG_W-1:0]        weight [FLAG_LANES];
        logic [LEN_W-1:0]        hold_ticks;
        bit                      armed [FLAG_LANES];
        bit                      inhib [FLAG_LANES];
        logic [LEN_W-1:0]        count [FLAG_LANES];
        logic signed [RES_W-1:0] residual [FLAG_LANES];
        t_tick_result            owed [$];
        int mismatches;
        int ticks;
        int discharges;
        int decays;

        function new();
            for (int k = 0; k < FLAG_LANES; k++) begin
                weight[k]   = MAG_RESET;
                armed[k]    = 1'b0;
                inhib[k]    = 1'b0;
                count[k]    = '0;
                residual[k] = '0;
            end
            hold_ticks = LEN_RESET;
            mismatches = 0;
            ticks      = 0;
            discharges = 0;
            decays     = 0;
        endfunction

        function logic signed [RES_W-1:0] clamp(longint v);
            if (v > RAIL_HI) begin
                return RAIL_HI[RES_W-1:0];
            end
            if (v < RAIL_LO) begin
                return RAIL_LO[RES_W-1:0];
            end
            return v[RES_W-1:0];
        endfunction

        function void set_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FIRST_MAG:  weight[0] = data[MAG_W-1:0];
                REG_SECOND_MAG: weight[1] = data[MAG_W-1:0];
                REG_THIRD_MAG:  weight[2] = data[MAG_W-1:0];
                REG_PULSE_LEN:  hold_ticks = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_tick(logic [FLAGS_W-1:0] flags, logic decay);
            longint       total;
            longint       w;
            t_tick_result want;
            total     = 0;
            want.mask = '0;
            ticks++;
            // flags arm first, inhibitory wins over excitatory
            for (int k = 0; k < FLAG_LANES; k++) begin
                if (flags[2*k] || flags[2*k+1]) begin
                    inhib[k] = flags[2*k+1];
                    armed[k] = 1'b1;
                    count[k] = '0;
                end
            end
            // armed dendrites count, and discharge into the residual at the length
            for (int k = 0; k < FLAG_LANES; k++) begin
                if (armed[k]) begin
                    count[k] = count[k] + 1'b1;
                    if (count[k] >= hold_ticks) begin
                        w = longint'(weight[k]);
                        armed[k] = 1'b0;
                        count[k] = '0;
                        residual[k] = clamp(longint'(residual[k]) + (inhib[k] ? -w : w));
                        discharges++;
                    end
                end
            end
            // decay by 127/128, truncated toward zero
            if (decay) begin
                decays++;
                for (int k = 0; k < FLAG_LANES; k++) begin
                    residual[k] = clamp((longint'(residual[k]) * DECAY_NUM) / DECAY_DEN);
                end
            end
            // potential: armed weights plus residuals
            for (int k = 0; k < FLAG_LANES; k++) begin
                if (armed[k]) begin
                    w = longint'(weight[k]);
                    total += inhib[k] ? -w : w;
                    want.mask[k] = 1'b1;
                end
                total += longint'(residual[k]);
            end
            want.potential = clamp(total);
            owed.push_back(want);
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        function void check_tick(logic signed [RES_W-1:0] potential, logic [MASK_W-1:0] mask);
            t_tick_result want;
            if (owed.size() == 0) begin
                $error("result word with nothing owed: potential %0d armed_mask %b",
                       potential, mask);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            if (potential !== want.potential) begin
                $error("potential mismatch: expected %0d, got %0d", want.potential, potential);
                mismatches++;
            end
            if (mask !== want.mask) begin
                $error("armed_mask mismatch: expected %b, got %b", want.mask, mask);
                mismatches++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [FLAGS_W-1:0]      i_pulse_flags;
    logic                    i_apply_decay;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [RES_W-1:0] o_potential;
    logic [MASK_W-1:0]       o_armed_mask;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    potential_tracker tracker;
    bit               no_stalls;
    int               settings_done;

    dendrite_pulse_integrator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pulse_flags (i_pulse_flags),
        .i_apply_decay (i_apply_decay),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_potential   (o_potential),
        .o_armed_mask  (o_armed_mask),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // idle length between words: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // sparse flags so pulses run to their end, with some fully random words
    function automatic logic [FLAGS_W-1:0] draw_flags(int odds, int noise_pct);
        logic [FLAGS_W-1:0] f;
        if ($urandom_range(0, 99) < noise_pct) begin
            return FLAGS_W'($urandom);
        end
        for (int b = 0; b < FLAGS_W; b++) begin
            f[b] = ($urandom_range(0, odds - 1) == 0);
        end
        return f;
    endfunction

    // present one tick word and hold it until taken
    task automatic send_tick(input logic [FLAGS_W-1:0] flags, input logic decay);
        int gap;
        i_valid       <= 1'b1;
        i_pulse_flags <= flags;
        i_apply_decay <= decay;
        do @(posedge i_clk); while (!o_ready);
        tracker.take_tick(flags, decay);
        gap = no_stalls ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // stop sending and wait for every owed result
    task automatic settle();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (tracker.outstanding() != 0);
    endtask

    // write all four registers; pulse length gets junk in the unused upper bits
    task automatic write_setting(input logic [MAG_W-1:0] m0, input logic [MAG_W-1:0] m1,
                                 input logic [MAG_W-1:0] m2, input logic [LEN_W-1:0] len);
        logic [CFG_DATA_W-1:0] word [4];
        t_cfg_reg              order [4];
        order   = '{REG_FIRST_MAG, REG_SECOND_MAG, REG_THIRD_MAG, REG_PULSE_LEN};
        word[0] = m0;
        word[1] = m1;
        word[2] = m2;
        word[3] = {(CFG_DATA_W-LEN_W)'($urandom), len};
        for (int r = 0; r < 4; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= order[r];
            i_cfg_data  <= word[r];
            tracker.set_register(order[r], word[r]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_done++;
    endtask

    // random ticks under one setting; first stretch runs without idling
    task automatic run_phase(input int items, input int odds, input int noise_pct,
                             input int decay_odds, input int pause_at);
        for (int i = 0; i < items; i++) begin
            if (i == pause_at) begin
                settle();
            end
            no_stalls = (i < 30);
            send_tick(draw_flags(odds, noise_pct), $urandom_range(0, decay_odds - 1) == 0);
        end
        no_stalls = 1'b0;
    endtask

    // result side: random stalls of varying length
    initial begin
        int r;
        int span;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (no_stalls) begin
                i_ready <= 1'b1;
                @(negedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    span = $urandom_range(1, 16);
                end else if (r < 94) begin
                    span = $urandom_range(1, 3);
                end else begin
                    span = $urandom_range(10, 40);
                end
                i_ready <= (r < 70);
                repeat (span) @(negedge i_clk);
            end
        end
    end

    // compare every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.check_tick(o_potential, o_armed_mask);
        end
    end

    initial begin
        #50ms;
        $error("timed out with %0d results owed", tracker.outstanding());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [LEN_W-1:0] len;
        tracker       = new();
        no_stalls     = 1'b0;
        settings_done = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_pulse_flags = '0;
        i_apply_decay = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_FIRST_MAG;
        i_cfg_data    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: single flags, both flags at once, decay
        send_tick(6'b000001, 1'b0);
        send_tick(6'b001000, 1'b0);
        send_tick(6'b110000, 1'b0);
        send_tick(6'b000000, 1'b1);
        send_tick(6'b111111, 1'b1);

        // full weights, length one: arm and discharge in the same tick
        settle();
        write_setting(MAG_MAX, MAG_MAX, MAG_MAX, 8'd1);
        send_tick(EX_ALL, 1'b0);
        send_tick(IH_ALL, 1'b0);
        send_tick(6'b111111, 1'b0);
        send_tick(6'b000000, 1'b1);
        send_tick(6'b000011, 1'b0);

        // length zero behaves like length one
        settle();
        write_setting('0, MAG_MAX, 15'd12345, 8'd0);
        send_tick(6'b000001, 1'b0);
        send_tick(6'b000110, 1'b0);
        send_tick(6'b101001, 1'b0);
        send_tick(6'b000000, 1'b1);

        // longest pulse
        settle();
        write_setting(15'd1, '0, MAG_MAX, LEN_MAX);
        send_tick(6'b111111, 1'b0);
        send_tick(EX_ALL, 1'b0);
        send_tick(6'b000000, 1'b0);
        send_tick(6'b100000, 1'b1);

        // short pulse running out on its own
        settle();
        write_setting(15'd20000, 15'd7, 15'd16384, 8'd3);
        send_tick(6'b000100, 1'b0);
        send_tick(6'b000000, 1'b0);
        send_tick(6'b000000, 1'b0);
        send_tick(6'b000000, 1'b1);

        // random phases, each under its own setting
        for (int p = 0; p < 5; p++) begin
            settle();
            case (p)
                0: begin
                    len = LEN_W'($urandom_range(2, 12));
                    write_setting(MAG_W'($urandom), MAG_W'($urandom), MAG_W'($urandom), len);
                end
                1: begin
                    len = '0;
                    write_setting(MAG_MAX, MAG_MAX, MAG_MAX, len);
                end
                2: begin
                    len = LEN_MAX;
                    write_setting('0, MAG_MAX, 15'd1, len);
                end
                3: begin
                    len = 8'd1;
                    write_setting(MAG_W'($urandom), MAG_W'($urandom), MAG_W'($urandom), len);
                end
                default: begin
                    len = LEN_W'($urandom_range(1, 40));
                    write_setting(MAG_W'($urandom), MAG_W'($urandom), MAG_W'($urandom), len);
                end
            endcase
            run_phase(p == 2 ? 500 : 200, 3 * len + $urandom_range(3, 24), p == 2 ? 0 : 8,
                      $urandom_range(2, 16), p == 2 ? 250 : -1);
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("covered %0d ticks over %0d register settings, %0d discharges, %0d decay ticks",
                 tracker.ticks, settings_done, tracker.discharges, tracker.decays);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
